FILE: rtl/bdq_pkg.sv
// ----------------------------------------------------------------------------
// bdq_pkg
// Shared constants, operation and status codes, and controller/datapath
// interface types for the bounded deque.
// ----------------------------------------------------------------------------
package bdq_pkg;

    localparam int DEPTH   = 16;
    localparam int PTR_W   = $clog2(DEPTH);
    localparam int CNT_W   = PTR_W + 1;
    localparam int WORD_W  = 32;
    localparam int FUNC_W  = 3;
    localparam int POS_W   = 4;
    localparam int STAT_W  = 2;

    localparam logic [FUNC_W-1:0] OP_PUSH_FRONT = 3'd0;
    localparam logic [FUNC_W-1:0] OP_PUSH_BACK  = 3'd1;
    localparam logic [FUNC_W-1:0] OP_POP_FRONT  = 3'd2;
    localparam logic [FUNC_W-1:0] OP_POP_BACK   = 3'd3;
    localparam logic [FUNC_W-1:0] OP_READ       = 3'd4;

    localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY     = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL      = 2'd2;
    localparam logic [STAT_W-1:0] ST_BAD_INDEX = 2'd3;

    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    typedef struct packed {
        logic load_in;   // capture request fields
        logic exec;      // update pointer/count, access store
        logic load_out;  // move result into output register
    } bdq_cmd_t;

    typedef struct packed {
        logic out_valid; // output register holds an untaken result
    } bdq_stat_t;

endpackage

FILE: rtl/bdq_ctrl.sv
// ----------------------------------------------------------------------------
// bdq_ctrl
// Sequencer: accept a request, execute it, hand the result to the output
// register once that register is free.
// ----------------------------------------------------------------------------
module bdq_ctrl import bdq_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  logic      m_ready,
    input  bdq_stat_t stat,
    output bdq_cmd_t  cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_WB   = 2'd2;

    logic [1:0] state_reg, state_next;
    logic       out_free;

    assign out_free = !stat.out_valid || m_ready;
    assign s_ready  = (state_reg == S_IDLE);

    always_comb begin
        state_next   = state_reg;
        cmd.load_in  = 1'b0;
        cmd.exec     = 1'b0;
        cmd.load_out = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.load_in = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC: begin
                cmd.exec   = 1'b1;
                state_next = S_WB;
            end
            S_WB: begin
                if (out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: rtl/bdq_dp.sv
// ----------------------------------------------------------------------------
// bdq_dp
// Datapath: request registers, ring store, front pointer, element count and
// the output register.
// ----------------------------------------------------------------------------
module bdq_dp import bdq_pkg::*; (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  bdq_cmd_t                 cmd,
    output bdq_stat_t                stat,
    input  logic [FUNC_W-1:0]        s_func,
    input  logic signed [WORD_W-1:0] s_value,
    input  logic [POS_W-1:0]         s_position,
    input  logic                     m_ready,
    output logic                     m_valid,
    output logic signed [WORD_W-1:0] m_read_value,
    output logic [STAT_W-1:0]        m_status,
    output logic [CNT_W-1:0]         m_occupancy,
    output logic                     m_is_empty
);

    logic [WORD_W-1:0] ring_mem [DEPTH];

    logic [FUNC_W-1:0]  func_reg;
    logic [WORD_W-1:0]  value_reg;
    logic [POS_W-1:0]   pos_reg;

    logic [PTR_W-1:0]   front_reg, front_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [STAT_W-1:0]  st_reg, st_next;
    logic               rd_ok_reg, rd_ok_next;
    logic [WORD_W-1:0]  rd_q_reg;

    logic               wr_en;
    logic [PTR_W-1:0]   wr_addr;
    logic [PTR_W-1:0]   rd_addr;
    logic               is_full, is_empty;

    logic               m_valid_reg;
    logic [WORD_W-1:0]  m_value_reg;
    logic [STAT_W-1:0]  m_status_reg;
    logic [CNT_W-1:0]   m_occ_reg;

    assign is_full  = (cnt_reg == CNT_FULL);
    assign is_empty = (cnt_reg == '0);
    assign rd_addr  = front_reg + PTR_W'(pos_reg);

    always_comb begin
        front_next = front_reg;
        cnt_next   = cnt_reg;
        st_next    = ST_OK;
        rd_ok_next = 1'b0;
        wr_en      = 1'b0;
        wr_addr    = front_reg - PTR_W'(1);
        unique case (func_reg)
            OP_PUSH_FRONT: begin
                if (is_full) begin
                    st_next = ST_FULL;
                end else begin
                    wr_en      = 1'b1;
                    front_next = front_reg - PTR_W'(1);
                    cnt_next   = cnt_reg + CNT_W'(1);
                end
            end
            OP_PUSH_BACK: begin
                wr_addr = front_reg + cnt_reg[PTR_W-1:0];
                if (is_full) begin
                    st_next = ST_FULL;
                end else begin
                    wr_en    = 1'b1;
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            OP_POP_FRONT: begin
                if (is_empty) begin
                    st_next = ST_EMPTY;
                end else begin
                    front_next = front_reg + PTR_W'(1);
                    cnt_next   = cnt_reg - CNT_W'(1);
                end
            end
            OP_POP_BACK: begin
                if (is_empty) begin
                    st_next = ST_EMPTY;
                end else begin
                    cnt_next = cnt_reg - CNT_W'(1);
                end
            end
            OP_READ: begin
                if (CNT_W'(pos_reg) < cnt_reg) begin
                    rd_ok_next = 1'b1;
                end else begin
                    st_next = ST_BAD_INDEX;
                end
            end
            default: begin
            end
        endcase
    end

    // request capture
    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            func_reg  <= s_func;
            value_reg <= s_value;
            pos_reg   <= s_position;
        end
    end

    // ring store, registered read
    always_ff @(posedge aclk) begin
        if (cmd.exec && wr_en) begin
            ring_mem[wr_addr] <= value_reg;
        end
        if (cmd.exec) begin
            rd_q_reg <= ring_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.exec) begin
            st_reg    <= st_next;
            rd_ok_reg <= rd_ok_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            front_reg <= '0;
            cnt_reg   <= '0;
        end else if (cmd.exec) begin
            front_reg <= front_next;
            cnt_reg   <= cnt_next;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            m_status_reg <= st_reg;
            m_occ_reg    <= cnt_reg;
            if (rd_ok_reg) begin
                m_value_reg <= rd_q_reg;
            end else if (st_reg == ST_BAD_INDEX) begin
                m_value_reg <= '1;
            end else begin
                m_value_reg <= '0;
            end
        end
    end

    assign stat.out_valid = m_valid_reg;
    assign m_valid        = m_valid_reg;
    assign m_read_value   = m_value_reg;
    assign m_status       = m_status_reg;
    assign m_occupancy    = m_occ_reg;
    assign m_is_empty     = (m_occ_reg == '0);

endmodule

FILE: rtl/bounded_deque_indexed_read.sv
// ----------------------------------------------------------------------------
// bounded_deque_indexed_read
// Bounded double-ended queue of signed 32-bit words with indexed read.
//
//   channel | direction | ports
//   --------+-----------+--------------------------------------------------
//   request | in        | s_valid s_ready s_func s_value s_position
//   result  | out       | m_valid m_ready m_read_value m_status
//           |           | m_occupancy m_is_empty
//
// One request at a time: accept, execute (store write or registered store
// read, pointer/count update), write-back. Synchronous active-low reset
// clears pointer, count and valids; the store is not cleared.
// A stalled result holds write-back; the next request is accepted while the
// previous result still waits in the output register.
// ----------------------------------------------------------------------------
module bounded_deque_indexed_read import bdq_pkg::*; (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [FUNC_W-1:0]        s_func,
    input  logic signed [WORD_W-1:0] s_value,
    input  logic [POS_W-1:0]         s_position,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic signed [WORD_W-1:0] m_read_value,
    output logic [STAT_W-1:0]        m_status,
    output logic [CNT_W-1:0]         m_occupancy,
    output logic                     m_is_empty
);

    bdq_cmd_t  cmd;
    bdq_stat_t stat;

    bdq_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    bdq_dp u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .stat         (stat),
        .s_func       (s_func),
        .s_value      (s_value),
        .s_position   (s_position),
        .m_ready      (m_ready),
        .m_valid      (m_valid),
        .m_read_value (m_read_value),
        .m_status     (m_status),
        .m_occupancy  (m_occupancy),
        .m_is_empty   (m_is_empty)
    );

endmodule

FILE: rtl/bdq_checker.sv
// ----------------------------------------------------------------------------
// bdq_checker
// Port-level checks for the bounded deque, bound to the top level.
// ----------------------------------------------------------------------------
module bdq_checker import bdq_pkg::*; (
    input logic                     aclk,
    input logic                     aresetn,
    input logic                     s_valid,
    input logic                     s_ready,
    input logic                     m_valid,
    input logic                     m_ready,
    input logic signed [WORD_W-1:0] m_read_value,
    input logic [STAT_W-1:0]        m_status,
    input logic [CNT_W-1:0]         m_occupancy,
    input logic                     m_is_empty
);

    a_empty_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_is_empty == (m_occupancy == '0)))
        else $error("empty flag disagrees with occupancy");

    a_occ_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_occupancy <= CNT_FULL))
        else $error("occupancy above depth");

    a_bad_index: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status == ST_BAD_INDEX) |-> (m_read_value == -32'sd1))
        else $error("bad index result not -1");

    a_one_inflight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("request accepted while one is executing");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_read_value)
                                   && $stable(m_status) && $stable(m_occupancy)))
        else $error("stalled result changed");

endmodule

bind bounded_deque_indexed_read bdq_checker u_bdq_checker (.*);
